>>> design/cadp_pkg.sv
`default_nettype none

package cadp_pkg;

    // Default number of tracked channels
    localparam int CHANNELS_DEFAULT = 126;

    // Field widths
    localparam int CHAN_W  = 7;
    localparam int LEVEL_W = 8;
    localparam int SHIFT_W = 3;
    localparam int COUNT_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HIT_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_SHIFT = 2'd2;

    localparam logic [LEVEL_W-1:0] HIT_GAIN_RST    = 8'd26;
    localparam logic [LEVEL_W-1:0] LEVEL_CAP_RST   = 8'd100;
    localparam logic [SHIFT_W-1:0] DECAY_SHIFT_RST = 3'd3;

    // Item kinds carried on tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

endpackage

`default_nettype wire

>>> design/channel_activity_decay_peak.sv
// Channel activity tracker with decay and per-sweep peak hold.
//
// Input stream (s_*): one transaction per detector sample. tdata carries the
// channel and the carrier-hit bit, tuser selects sample or clear-all, and
// tlast marks the final sample of a sweep. Result stream (m_*): exactly one
// transaction per input transaction, in order. tdata carries the channel,
// its updated level and, on sweep end (tlast high), the sweep peak, a
// peak-found flag and the wrapping sweep count; these are zero otherwise.
//
// Throughput is one item per cycle unless a low m_tready stalls the output.
// Each item makes a single read-modify-write of the level memory: the read
// is issued at acceptance, the update at commit from the update stage, and a
// forwarding register covers a back-to-back hit on the same channel.
//
// Reset clears all per-channel valid bits (every level reads as zero), the
// running peak, the sweep count, and restores the configuration defaults.
// When the receiver holds m_tready low, the output register holds its
// transaction, one more item waits in the update stage, and s_tready drops.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata;
// the user must write them only while the block is idle; the block itself does not enforce it.

`default_nettype none

module channel_activity_decay_peak #(
    parameter int CHANNELS = cadp_pkg::CHANNELS_DEFAULT
) (
    input  wire                                aclk,
    input  wire                                aresetn,

    // Input stream
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [cadp_pkg::IN_TDATA_W-1:0]    s_tdata,   // [6:0] channel, [7] carrier_hit
    input  wire                                s_tuser,   // [0] op
    input  wire                                s_tlast,   // sweep_end

    // Result stream
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // [6:0] channel_out, [14:7] level, [21:15] peak_channel, [29:22] peak_level,
    // [30] peak_found, [46:31] sweep_count, [47] zero
    output logic [cadp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast,   // sweep_done

    // Configuration write port
    input  wire                                cfg_wr_en,
    input  wire  [cadp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [cadp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import cadp_pkg::*;

    localparam int IDX_W = $clog2(CHANNELS);

    // Configuration registers
    logic [LEVEL_W-1:0] hit_gain_reg;
    logic [LEVEL_W-1:0] level_cap_reg;
    logic [SHIFT_W-1:0] decay_shift_reg;

    // Level storage
    logic [LEVEL_W-1:0] level_mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    logic [LEVEL_W-1:0]  rd_data_reg;
    logic                fwd_hit_reg;
    logic [LEVEL_W-1:0]  fwd_data_reg;

    // Update stage
    logic               s1_valid_reg;
    logic               s1_op_reg;
    logic [CHAN_W-1:0]  s1_chan_reg;
    logic               s1_hit_reg;
    logic               s1_last_reg;

    // Sweep state
    logic [LEVEL_W-1:0] run_peak_level_reg;
    logic [CHAN_W-1:0]  run_peak_chan_reg;
    logic [COUNT_W-1:0] sweep_count_reg;

    // Combinational signals
    logic               s_accept;
    logic               advance;
    logic               commit;
    logic [CHAN_W-1:0]  in_chan;
    logic [IDX_W-1:0]   in_idx;
    logic [IDX_W-1:0]   s1_idx;
    logic               s1_in_range;
    logic               s1_sample;
    logic               s1_write;
    logic [LEVEL_W-1:0] old_level;
    logic [LEVEL_W-1:0] decayed;
    logic [LEVEL_W:0]   gained;
    logic [LEVEL_W-1:0] new_level;
    logic [LEVEL_W-1:0] item_level;
    logic               peak_upd;
    logic [LEVEL_W-1:0] peak_level_next;
    logic [CHAN_W-1:0]  peak_chan_next;
    logic [COUNT_W-1:0] sweep_count_next;

    // Handshake
    assign advance  = !m_tvalid || m_tready;
    assign commit   = s1_valid_reg && advance;
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_chan = s_tdata[CHAN_W-1:0];
    assign in_idx  = IDX_W'(in_chan);
    assign s1_idx  = IDX_W'(s1_chan_reg);

    assign s1_in_range = (32'(s1_chan_reg) < 32'(CHANNELS));
    assign s1_sample   = (s1_op_reg == OP_SAMPLE);
    assign s1_write    = commit && s1_sample && s1_in_range;

    // Current level: invalid entries read as zero, a write just made wins
    always_comb begin
        if (!s1_in_range || !valid_reg[s1_idx]) begin
            old_level = '0;
        end else if (fwd_hit_reg) begin
            old_level = fwd_data_reg;
        end else begin
            old_level = rd_data_reg;
        end
    end

    // Decay, gain, cap
    always_comb begin
        decayed = old_level - (old_level >> decay_shift_reg);
        gained  = {1'b0, decayed} + (s1_hit_reg ? {1'b0, hit_gain_reg} : '0);
        if (gained > {1'b0, level_cap_reg}) begin
            new_level = level_cap_reg;
        end else begin
            new_level = gained[LEVEL_W-1:0];
        end
        item_level = s1_in_range ? new_level : '0;
    end

    // Running peak including this item
    always_comb begin
        peak_upd         = s1_in_range && (new_level > run_peak_level_reg);
        peak_level_next  = peak_upd ? new_level : run_peak_level_reg;
        peak_chan_next   = peak_upd ? s1_chan_reg : run_peak_chan_reg;
        sweep_count_next = sweep_count_reg + COUNT_W'(1);
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_gain_reg    <= HIT_GAIN_RST;
            level_cap_reg   <= LEVEL_CAP_RST;
            decay_shift_reg <= DECAY_SHIFT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HIT_GAIN:    hit_gain_reg    <= cfg_wdata[LEVEL_W-1:0];
                REG_LEVEL_CAP:   level_cap_reg   <= cfg_wdata[LEVEL_W-1:0];
                REG_DECAY_SHIFT: decay_shift_reg <= cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Level memory: read at acceptance, write at commit
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= level_mem[in_idx];
        end
        if (s1_write) begin
            level_mem[s1_idx] <= new_level;
        end
    end

    // Forwarding for a same-channel item right behind
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (s_accept) begin
            fwd_hit_reg <= s1_write && (s1_chan_reg == in_chan);
        end else if (commit) begin
            fwd_hit_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_data_reg <= new_level;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (commit && !s1_sample) begin
            valid_reg <= '0;
        end else if (s1_write) begin
            valid_reg[s1_idx] <= 1'b1;
        end
    end

    // Update stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (commit) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_op_reg   <= s_tuser;
            s1_chan_reg <= in_chan;
            s1_hit_reg  <= s_tdata[CHAN_W];
            s1_last_reg <= s_tlast;
        end
    end

    // Sweep peak and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_peak_level_reg <= '0;
            run_peak_chan_reg  <= '0;
            sweep_count_reg    <= '0;
        end else if (commit) begin
            if (!s1_sample || s1_last_reg) begin
                run_peak_level_reg <= '0;
                run_peak_chan_reg  <= '0;
            end else begin
                run_peak_level_reg <= peak_level_next;
                run_peak_chan_reg  <= peak_chan_next;
            end
            if (s1_sample && s1_last_reg) begin
                sweep_count_reg <= sweep_count_next;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (commit) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            if (!s1_sample) begin
                m_tdata <= {{(OUT_TDATA_W-CHAN_W){1'b0}}, s1_chan_reg};
                m_tlast <= 1'b0;
            end else if (s1_last_reg) begin
                m_tdata <= {1'b0, sweep_count_next, (peak_level_next != '0),
                            peak_level_next, peak_chan_next, item_level, s1_chan_reg};
                m_tlast <= 1'b1;
            end else begin
                m_tdata <= {{(OUT_TDATA_W-CHAN_W-LEVEL_W){1'b0}}, item_level, s1_chan_reg};
                m_tlast <= 1'b0;
            end
        end
    end

    // Checks
    a_level_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:7] <= level_cap_reg))
        else $error("reported level above cap");

    a_peak_covers_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[29:22] >= m_tdata[14:7]))
        else $error("sweep peak below the last level");

    a_clear_drops_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && !s1_sample) |=> (valid_reg == '0))
        else $error("clear left a valid level");

    a_fwd_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forwarding flag without an item in the update stage");

    a_no_peak_mid_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[47:15] == '0))
        else $error("peak fields set outside a sweep end");

endmodule

`default_nettype wire
